FILE: sv/ymr_pkg.sv
package ymr_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } ymr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [9:0]  data_offset;
    logic [2:0]  packet_status;
    logic [10:0] commit_length;
    logic [31:0] file_position;
    logic        last;
  } ymr_out_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_BODY = 2'd2
  } ymr_phase_t;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_TIMEOUT = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [2:0] ST_DATA_OK  = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_EOT      = 3'd3;
  localparam logic [2:0] ST_CANCEL   = 3'd4;
  localparam logic [2:0] ST_CHECK    = 3'd5;
  localparam logic [2:0] ST_TIMEOUTS = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_STX  = 8'h02;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_ACK  = 8'h06;
  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_SYNC = 8'h43;

  localparam logic [2:0] CFG_CRC_EN    = 3'd0;
  localparam logic [2:0] CFG_SEQ_EN    = 3'd1;
  localparam logic [2:0] CFG_RETRY_INI = 3'd2;
  localparam logic [2:0] CFG_RETRY_DAT = 3'd3;
  localparam logic [2:0] CFG_MAX_FILE  = 3'd4;

  localparam int SHORT_BLOCK_BYTES = 128;

  // Up to four result slots per item, carried as one record through the queue
  typedef struct packed {
    logic [2:0]  count;   // 0..4
    ymr_out_t    r0;
    ymr_out_t    r1;
    ymr_out_t    r2;
    ymr_out_t    r3;
  } ymr_group_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/ymr_front.sv
// Protocol engine: consumes one beat per cycle while step is high, produces a result group.
module ymr_front #(
  parameter int LONG_BLOCK_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              step,
  input  ymr_pkg::ymr_in_t  item,
  output ymr_pkg::ymr_group_t grp
);
  import ymr_pkg::*;

  localparam int PW = $clog2(LONG_BLOCK_BYTES + 4) + 1;

  logic        crc_en_r, seq_en_r;
  logic [7:0]  retry_ini_r, retry_dat_r;
  logic [31:0] max_file_r;

  ymr_phase_t  phase_r, phase_nxt;
  logic [31:0] pkt_num_r, pkt_num_nxt;
  logic        long_r, long_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]  seq_r, seq_nxt, cmp_r, cmp_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [31:0] committed_r, committed_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic [7:0]  sync_r, sync_nxt;
  logic [1:0]  sp_r, sp_nxt;
  logic [31:0] acc_r, acc_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r    <= 1'b0;
      seq_en_r    <= 1'b0;
      retry_ini_r <= 8'd30;
      retry_dat_r <= 8'd10;
      max_file_r  <= 32'd1048576;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CRC_EN:    crc_en_r    <= cfg_data[0];
        CFG_SEQ_EN:    seq_en_r    <= cfg_data[0];
        CFG_RETRY_INI: retry_ini_r <= cfg_data[7:0];
        CFG_RETRY_DAT: retry_dat_r <= cfg_data[7:0];
        CFG_MAX_FILE:  max_file_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pkt_num_r   <= '0;
      long_r      <= 1'b0;
      pos_r       <= '0;
      seq_r       <= '0;
      cmp_r       <= '0;
      crc_r       <= '0;
      crc_hi_r    <= '0;
      committed_r <= '0;
      limit_r     <= 32'd1048576;
      retries_r   <= 8'd30;
      sync_r      <= B_SYNC;
      sp_r        <= '0;
      acc_r       <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      pkt_num_r   <= pkt_num_nxt;
      long_r      <= long_nxt;
      pos_r       <= pos_nxt;
      seq_r       <= seq_nxt;
      cmp_r       <= cmp_nxt;
      crc_r       <= crc_nxt;
      crc_hi_r    <= crc_hi_nxt;
      committed_r <= committed_nxt;
      limit_r     <= limit_nxt;
      retries_r   <= retries_nxt;
      sync_r      <= sync_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
    end
  end

  logic [PW-1:0] psize;
  logic [31:0]   room, commit32;
  logic [7:0]    rdec, b;
  logic [15:0]   crc_full;
  ymr_out_t      res [4];
  logic [2:0]    n;

  function automatic ymr_out_t mk(input logic [1:0] k, input logic [7:0] v,
                                  input logic [9:0] off, input logic [2:0] st,
                                  input logic [10:0] cl, input logic [31:0] fp);
    ymr_out_t o;
    o.kind = k; o.byte_value = v; o.data_offset = off; o.packet_status = st;
    o.commit_length = cl; o.file_position = fp; o.last = 1'b0;
    return o;
  endfunction

  // next state and result list
  always_comb begin
    phase_nxt = phase_r; pkt_num_nxt = pkt_num_r; long_nxt = long_r;
    pos_nxt = pos_r; seq_nxt = seq_r; cmp_nxt = cmp_r; crc_nxt = crc_r;
    crc_hi_nxt = crc_hi_r; committed_nxt = committed_r; limit_nxt = limit_r;
    retries_nxt = retries_r; sync_nxt = sync_r; sp_nxt = sp_r; acc_nxt = acc_r;
    for (int i = 0; i < 4; i++) res[i] = '0;
    n = '0;
    b = item.rx_byte;
    psize = long_r ? PW'(LONG_BLOCK_BYTES) : PW'(SHORT_BLOCK_BYTES);
    rdec = retries_r - 8'd1;
    crc_full = {crc_hi_r, b};
    room = (committed_r >= limit_r) ? 32'd0 : (limit_r - committed_r);
    commit32 = (32'(psize) > room) ? room : 32'(psize);

    case (item.action)
      ACT_START: begin
        pkt_num_nxt = '0; committed_nxt = '0; limit_nxt = max_file_r;
        retries_nxt = retry_ini_r; sync_nxt = B_SYNC; phase_nxt = PH_WAIT;
        res[0] = mk(KIND_SEND, B_SYNC, '0, '0, '0, '0); n = 3'd1;
      end
      ACT_TIMEOUT: begin
        if (phase_r != PH_IDLE) begin
          retries_nxt = rdec;
          if (rdec == 8'd0) begin
            res[0] = mk(KIND_SEND, B_CAN, '0, '0, '0, '0);
            res[1] = res[0];
            res[2] = mk(KIND_VERDICT, '0, '0, ST_TIMEOUTS, '0, committed_r);
            n = 3'd3; phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_WAIT;
            res[0] = mk(KIND_SEND, sync_r, '0, '0, '0, '0); n = 3'd1;
          end
        end
      end
      ACT_BYTE: begin
        if (phase_r == PH_WAIT) begin
          if (b == B_STX || b == B_SOH) begin
            phase_nxt = PH_BODY; long_nxt = (b == B_STX); pos_nxt = '0;
            crc_nxt = '0; crc_hi_nxt = '0; sp_nxt = '0; acc_nxt = '0;
          end else if (b == B_CAN) begin
            res[0] = mk(KIND_VERDICT, '0, '0, ST_CANCEL, '0, committed_r);
            n = 3'd1; phase_nxt = PH_IDLE;
          end else if (b == B_EOT) begin
            sync_nxt = B_SYNC; pkt_num_nxt = '0;
            res[0] = mk(KIND_SEND, B_ACK, '0, '0, '0, '0);
            res[1] = mk(KIND_VERDICT, '0, '0, ST_EOT, '0, committed_r);
            res[2] = mk(KIND_SEND, B_SYNC, '0, '0, '0, '0);
            n = 3'd3;
          end
        end else if (phase_r == PH_BODY) begin
          pos_nxt = pos_r + 1'b1;
          if (pos_r == '0) begin
            seq_nxt = b;
          end else if (pos_r == PW'(1)) begin
            cmp_nxt = b;
          end else if (pos_r < psize + PW'(2)) begin
            res[0] = mk(KIND_DATA, b, 10'(pos_r - PW'(2)), '0, '0, '0); n = 3'd1;
            crc_nxt = crc_step(crc_r, b);
            if (sp_r == 2'd0) begin
              if (b == 8'd0) sp_nxt = 2'd1;
            end else if (sp_r == 2'd1) begin
              if (b >= 8'h30 && b <= 8'h39)
                acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, b[3:0]};
              else
                sp_nxt = 2'd2;
            end
          end else if (pos_r == psize + PW'(2)) begin
            crc_hi_nxt = b;
          end else begin
            // trailer complete: verdict
            phase_nxt = PH_WAIT;
            if ((seq_en_r && seq_r != ~cmp_r) || (crc_en_r && crc_full != crc_r)) begin
              res[0] = mk(KIND_SEND, B_CAN, '0, '0, '0, '0); res[1] = res[0];
              res[2] = mk(KIND_VERDICT, '0, '0, ST_CHECK, '0, committed_r);
              n = 3'd3; phase_nxt = PH_IDLE;
            end else if (seq_r == 8'(pkt_num_r - 32'd1)) begin
              res[0] = mk(KIND_VERDICT, '0, '0, ST_DUP, '0, committed_r);
              res[1] = mk(KIND_SEND, sync_r, '0, '0, '0, '0); n = 3'd2;
            end else if (seq_en_r && seq_r != pkt_num_r[7:0]) begin
              res[0] = mk(KIND_SEND, B_CAN, '0, '0, '0, '0); res[1] = res[0];
              res[2] = mk(KIND_VERDICT, '0, '0, ST_CHECK, '0, committed_r);
              n = 3'd3; phase_nxt = PH_IDLE;
            end else if (pkt_num_r == '0) begin
              pkt_num_nxt = 32'd1;
              res[0] = mk(KIND_SEND, B_ACK, '0, '0, '0, '0);
              if (acc_r == '0) begin
                res[1] = mk(KIND_VERDICT, '0, '0, ST_EMPTY, '0, committed_r);
                n = 3'd2; phase_nxt = PH_IDLE;
              end else begin
                limit_nxt = acc_r;
                res[1] = mk(KIND_VERDICT, '0, '0, ST_HEADER, '0, committed_r);
                res[2] = mk(KIND_SEND, sync_r, '0, '0, '0, '0); n = 3'd3;
              end
            end else begin
              retries_nxt = retry_dat_r; sync_nxt = B_ACK;
              res[0] = mk(KIND_VERDICT, '0, '0, ST_DATA_OK, 11'(commit32), committed_r);
              committed_nxt = committed_r + commit32;
              pkt_num_nxt = pkt_num_r + 32'd1;
              res[1] = mk(KIND_SEND, B_ACK, '0, '0, '0, '0); n = 3'd2;
            end
          end
        end
      end
      default: ;
    endcase

    for (int i = 0; i < 4; i++) res[i].last = (3'(i + 1) == n);
    grp.count = n;
    grp.r0 = res[0]; grp.r1 = res[1]; grp.r2 = res[2]; grp.r3 = res[3];
  end

endmodule

FILE: sv/ymr_queue.sv
// Two-entry FIFO of result groups between engine and output sequencer.
module ymr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ymr_pkg::ymr_group_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output ymr_pkg::ymr_group_t rdata
);
  import ymr_pkg::*;

  ymr_group_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/ymr_back.sv
// Output sequencer: emits the results of one group, one beat per cycle while out_stall is low.
module ymr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  ymr_pkg::ymr_group_t grp,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ymr_pkg::ymr_out_t   out_data
);
  import ymr_pkg::*;

  logic [1:0] idx_r;
  logic       fire;

  assign out_valid = !empty;
  assign fire      = out_valid && !out_stall;
  assign pop       = fire && ({1'b0, idx_r} + 3'd1 == grp.count);

  always_comb begin
    case (idx_r)
      2'd0:    out_data = grp.r0;
      2'd1:    out_data = grp.r1;
      2'd2:    out_data = grp.r2;
      default: out_data = grp.r3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (pop) idx_r <= '0;
    else if (fire) idx_r <= idx_r + 2'd1;
  end

endmodule

FILE: sv/ymodem_packet_receiver_core.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | ymr_in_t  (action, rx_byte)
// out_    | output    | out_valid / out_stall| ymr_out_t (one result per beat)
// cfg_    | input     | cfg_write            | cfg_index, cfg_data
//
// The engine takes one input beat per cycle unless the queue is full; an item's
// results (up to three) leave one beat per cycle, out_stall permitting, from a
// two-entry group queue, so the sustained input rate is one item per cycle unless
// an item makes several results. Items causing no result use no queue space.
// Reset is synchronous (rst_n low); in_stall is high only when the queue is full.
module ymodem_packet_receiver_core #(
  parameter int LONG_BLOCK_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ymr_pkg::ymr_in_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ymr_pkg::ymr_out_t   out_data
);
  import ymr_pkg::*;

  ymr_group_t grp, qdata;
  logic       step, full, empty, pop;

  assign in_stall = full;
  assign step     = in_valid && !full;

  ymr_front #(.LONG_BLOCK_BYTES(LONG_BLOCK_BYTES)) u_front (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
    .step, .item(in_data), .grp
  );

  ymr_queue u_queue (
    .clk, .rst_n, .push(step && grp.count != 3'd0), .wdata(grp), .full,
    .pop, .empty, .rdata(qdata)
  );

  ymr_back u_back (
    .clk, .rst_n, .empty, .grp(qdata), .pop, .out_valid, .out_stall, .out_data
  );

endmodule
